// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the padding parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== src/tpp_pkg.sv =====
// Types, constants and the character time table of the terminal padding parser.
`default_nettype none

package tpp_pkg;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int LINES_W   = 8;
    localparam int SPEED_W   = 4;
    localparam int COUNT_W   = 23;
    localparam int WHOLE_W   = 14;
    localparam int TENTH_W   = 4;
    localparam int TENTHS_W  = 17;
    localparam int PROD_W    = TENTHS_W + LINES_W;
    localparam int DIVISOR_W = 11;
    localparam int REM_W     = DIVISOR_W + 1;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    // Parse limits and characters
    localparam logic [TENTHS_W-1:0] WHOLE_MAX = TENTHS_W'(9999);
    localparam logic [CHAR_W-1:0]   CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0]   CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0]   CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]   CH_NINE   = 8'h39;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR   = 2'd1;

    // Speed codes outside the table
    localparam logic [SPEED_W-1:0] SPEED_OFF  = 4'd0;
    localparam logic [SPEED_W-1:0] SPEED_OVER = 4'd15;

    // Output kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [CHAR_W-1:0]  char_in;
        logic [LINES_W-1:0] affected_lines;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  out_char;
        logic [COUNT_W-1:0] pad_count;
    } t_out;

    typedef enum logic [1:0] {
        PH_INT,
        PH_DOT,
        PH_SKIP,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept_char;
        logic start_end;
        logic mul;
        logic add;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_last;
    } t_status;

    // Per-character time in tenths of a millisecond for each speed code
    function automatic logic [DIVISOR_W-1:0] char_time(input logic [SPEED_W-1:0] code);
        logic [DIVISOR_W-1:0] m;
        unique case (code)
            4'd1:    m = 11'd2000;
            4'd2:    m = 11'd1333;
            4'd3:    m = 11'd909;
            4'd4:    m = 11'd743;
            4'd5:    m = 11'd666;
            4'd6:    m = 11'd500;
            4'd7:    m = 11'd333;
            4'd8:    m = 11'd166;
            4'd9:    m = 11'd83;
            4'd10:   m = 11'd55;
            4'd11:   m = 11'd41;
            4'd12:   m = 11'd20;
            4'd13:   m = 11'd10;
            4'd14:   m = 11'd5;
            default: m = 11'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/tpp_ctrl.sv =====
// Controller state machine: input acceptance and sequencing of the end-of-string count.
`default_nettype none

module tpp_ctrl
    import tpp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_end,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_end == CMD_END) begin
                        o_cmd.start_end = 1'b1;
                        n_state         = ST_MUL;
                    end else begin
                        o_cmd.accept_char = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tpp_dp.sv =====
// Datapath: prefix parse state, configuration, multiplier, serial divider, output register.
`default_nettype none

module tpp_dp
    import tpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire t_in                  i_in_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CHAR_W-1:0]    i_cfg_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output t_out                      o_out_data
);

    // Parse state
    t_phase               r_phase, n_phase;
    logic [WHOLE_W-1:0]   r_whole, n_whole;
    logic [TENTH_W-1:0]   r_tenth, n_tenth;
    logic                 r_star,  n_star;

    // Configuration
    logic [SPEED_W-1:0]   r_speed;
    logic [CHAR_W-1:0]    r_pad;

    // End-of-string arithmetic
    logic [TENTHS_W-1:0]  r_tenths;
    logic [LINES_W-1:0]   r_lines;
    logic                 r_use_star;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    r_dq;
    logic [REM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;

    // Output register
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out_data,  n_out_data;

    logic                 w_digit;
    logic [TENTH_W-1:0]   w_dval;
    logic [TENTHS_W-1:0]  w_whole_ext;
    logic [TENTHS_W-1:0]  w_whole_next;
    logic [TENTHS_W-1:0]  w_tenths;
    logic                 w_emit;
    logic [DIVISOR_W-1:0] w_m;
    logic                 w_pad_ok;
    logic [PROD_W-1:0]    w_prod;
    logic [REM_W-1:0]     w_trial;
    logic                 w_ge;
    logic                 w_load;

    // Decode the incoming character
    assign w_digit      = (i_in_data.char_in >= CH_ZERO) && (i_in_data.char_in <= CH_NINE);
    assign w_dval       = TENTH_W'(i_in_data.char_in - CH_ZERO);
    assign w_whole_ext  = {{(TENTHS_W-WHOLE_W){1'b0}}, r_whole};
    assign w_whole_next = (w_whole_ext << 3) + (w_whole_ext << 1)
                        + {{(TENTHS_W-TENTH_W){1'b0}}, w_dval};
    assign w_tenths     = (w_whole_ext << 3) + (w_whole_ext << 1)
                        + {{(TENTHS_W-TENTH_W){1'b0}}, r_tenth};

    // Divisor from the speed table
    assign w_m      = char_time(r_speed);
    assign w_pad_ok = (r_speed != SPEED_OFF) && (r_speed != SPEED_OVER);

    // Delay times line count
    assign w_prod = {{(PROD_W-TENTHS_W){1'b0}}, r_tenths}
                  * {{(PROD_W-LINES_W){1'b0}}, r_lines};

    // One restoring divide step
    assign w_trial = {r_rem[REM_W-2:0], r_dq[PROD_W-1]};
    assign w_ge    = w_trial >= {1'b0, w_m};

    // Status
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // Prefix parser: advance phase, accumulate delay, decide on pass-through
    always_comb begin
        n_phase = r_phase;
        n_whole = r_whole;
        n_tenth = r_tenth;
        n_star  = r_star;
        w_emit  = 1'b0;
        if (i_cmd.accept_char) begin
            unique case (r_phase)
                PH_INT: begin
                    if (w_digit) begin
                        n_whole = (w_whole_next > WHOLE_MAX) ? WHOLE_MAX[WHOLE_W-1:0]
                                                             : w_whole_next[WHOLE_W-1:0];
                    end else if (i_in_data.char_in == CH_DOT) begin
                        n_phase = PH_DOT;
                    end else begin
                        n_phase = PH_BODY;
                        if (i_in_data.char_in == CH_STAR) n_star = 1'b1;
                        else                               w_emit = 1'b1;
                    end
                end
                PH_DOT: begin
                    if (w_digit) begin
                        n_tenth = w_dval;
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_BODY;
                        if (i_in_data.char_in == CH_STAR) n_star = 1'b1;
                        else                               w_emit = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (!w_digit) begin
                        n_phase = PH_BODY;
                        if (i_in_data.char_in == CH_STAR) n_star = 1'b1;
                        else                               w_emit = 1'b1;
                    end
                end
                PH_BODY: begin
                    w_emit = 1'b1;
                end
            endcase
        end
        // Drop the parse state once the end result is loaded into the output register
        if (i_cmd.finish) begin
            n_phase = PH_INT;
            n_whole = '0;
            n_tenth = '0;
            n_star  = 1'b0;
        end
    end

    // Output register: load a result or drain on a taken transaction
    assign w_load = (i_cmd.accept_char && w_emit) || i_cmd.finish;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_load) begin
            n_out_valid = 1'b1;
            if (i_cmd.finish) begin
                n_out_data.kind      = KIND_END;
                n_out_data.out_char  = r_pad;
                n_out_data.pad_count = w_pad_ok ? r_dq[COUNT_W-1:0] : '0;
            end else begin
                n_out_data.kind      = KIND_CHAR;
                n_out_data.out_char  = i_in_data.char_in;
                n_out_data.pad_count = '0;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INT;
            r_whole     <= '0;
            r_tenth     <= '0;
            r_star      <= 1'b0;
            r_speed     <= '0;
            r_pad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_whole     <= n_whole;
            r_tenth     <= n_tenth;
            r_star      <= n_star;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED_CODE: r_speed <= i_cfg_data[SPEED_W-1:0];
                    CFG_PAD_CHAR:   r_pad   <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        // Capture delay and line count of the end transaction
        if (i_cmd.start_end) begin
            r_tenths   <= w_tenths;
            r_lines    <= i_in_data.affected_lines;
            r_use_star <= r_star;
        end
        // Scale by the line count when a star was seen
        if (i_cmd.mul) begin
            r_prod <= r_use_star ? w_prod : {{(PROD_W-TENTHS_W){1'b0}}, r_tenths};
        end
        // Add half a character time and start the divider
        if (i_cmd.add) begin
            r_dq  <= r_prod + {{(PROD_W-DIVISOR_W){1'b0}}, (w_m >> 1)};
            r_rem <= '0;
            r_cnt <= '0;
        end
        // Shift in one quotient bit
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_trial - {1'b0, w_m}) : w_trial;
            r_dq  <= {r_dq[PROD_W-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/terminal_padding_parser.sv =====
// A passed-through character appears in the output register in the cycle after acceptance.
// Throughput: one character transaction per cycle while the output side keeps up.
// An end transaction runs through capture, multiply, add, 25 divide steps in the
// one-bit-per-cycle divider, and load; the load waits while the output side stalls.
// Reset: synchronous, active low; clears parse state and both registers, empties the output.
// Top level of the terminal padding parser.
`default_nettype none

module terminal_padding_parser
    import tpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CHAR_W-1:0]    i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // Registers always take a write
    assign o_cfg_ready = 1'b1;

    tpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_end   (i_in_data.cmd),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tpp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/tpp_checker.sv =====
// Port-level checker of the terminal padding parser and its bind.
`default_nettype none
`include "assert_macros.svh"

module tpp_checker
    import tpp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire t_in                  i_in_data,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_out                 o_out_data
);

    logic w_end_accept;

    assign w_end_accept = i_in_valid && !o_in_stall && (i_in_data.cmd == CMD_END);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // Busy computing the count after an end transaction
    `ASSERT_NEXT(a_end_busy, i_clk, i_rst_n, w_end_accept, o_in_stall)

    // Character results carry no pad count
    `ASSERT_IMPLY(a_char_no_pad, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_CHAR),
                  o_out_data.pad_count == '0)

endmodule

bind terminal_padding_parser tpp_checker u_tpp_checker (.*);

`default_nettype wire

// ===== sim/terminal_padding_parser_tb.sv =====
// Self-checking testbench for the terminal padding parser: directed table, then random strings.
`default_nettype none

module terminal_padding_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpp_pkg::*;

    localparam int QUIET_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int MAX_REPORTS     = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;

    // One row of the directed table: a register write or an input transaction
    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CHAR_W-1:0]    reg_val;
        t_in                  item;
        logic                 typed;
        t_out                 want;
    } t_stim_row;

    // DUT connections
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAR_W-1:0]    cfg_data  = '0;

    // Parser mirror: parse state and registers
    t_phase            prs_phase   = PH_INT;
    int unsigned       whole_ms    = 0;
    int unsigned       tenth_digit = 0;
    bit                star_seen   = 1'b0;
    logic [SPEED_W-1:0] speed_reg  = '0;
    logic [CHAR_W-1:0] pad_reg     = '0;

    // Per-character time in tenths of a millisecond, by speed code
    int unsigned char_tenths [0:14] = '{0, 2000, 1333, 909, 743, 666, 500, 333, 166, 83, 55,
                                        41, 20, 10, 5};

    t_out      out_due [$];
    t_stim_row rows [$];
    int        miss_count  = 0;
    int        items_sent  = 0;
    int        gap_pct     = 0;
    int        stall_pct   = 0;
    int        quiet_count = 0;

    terminal_padding_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the parser mirror by one transaction; return 1 when it yields a result
    function automatic bit parse_step(input t_in it, output t_out res);
        int unsigned tenths;
        int unsigned m;
        int unsigned v;
        logic [CHAR_W-1:0] c;
        bit is_dig;
        res    = '0;
        c      = it.char_in;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        if (it.cmd == CMD_END) begin
            tenths = whole_ms * 10 + tenth_digit;
            if (star_seen) tenths = tenths * it.affected_lines;
            res.kind     = KIND_END;
            res.out_char = pad_reg;
            if (tenths != 0 && speed_reg != SPEED_OFF && speed_reg != SPEED_OVER) begin
                m = char_tenths[speed_reg];
                res.pad_count = COUNT_W'((tenths + m / 2) / m);
            end
            prs_phase   = PH_INT;
            whole_ms    = 0;
            tenth_digit = 0;
            star_seen   = 1'b0;
            return 1'b1;
        end
        case (prs_phase)
            PH_INT: begin
                if (is_dig) begin
                    v = whole_ms * 10 + (int'(c) - int'(CH_ZERO));
                    whole_ms = (v > 9999) ? 9999 : v;
                    return 1'b0;
                end
                if (c == CH_DOT) begin
                    prs_phase = PH_DOT;
                    return 1'b0;
                end
            end
            PH_DOT: begin
                if (is_dig) begin
                    tenth_digit = int'(c) - int'(CH_ZERO);
                    prs_phase   = PH_SKIP;
                    return 1'b0;
                end
            end
            PH_SKIP: begin
                if (is_dig) return 1'b0;
            end
            default: ;
        endcase
        // First non-prefix character ends the prefix; a star here is swallowed
        if (prs_phase != PH_BODY) begin
            prs_phase = PH_BODY;
            if (c == CH_STAR) begin
                star_seen = 1'b1;
                return 1'b0;
            end
        end
        res.kind     = KIND_CHAR;
        res.out_char = c;
        return 1'b1;
    endfunction

    function automatic t_stim_row feed(input logic cmd, input logic [CHAR_W-1:0] ch,
                                       input logic [LINES_W-1:0] lines);
        t_stim_row r;
        r      = '0;
        r.item = '{cmd: cmd, char_in: ch, affected_lines: lines};
        return r;
    endfunction

    function automatic t_stim_row feed_want(input logic cmd, input logic [CHAR_W-1:0] ch,
                                            input logic [LINES_W-1:0] lines, input logic kind,
                                            input logic [CHAR_W-1:0] och,
                                            input logic [COUNT_W-1:0] count);
        t_stim_row r;
        r       = feed(cmd, ch, lines);
        r.typed = 1'b1;
        r.want  = '{kind: kind, out_char: och, pad_count: count};
        return r;
    endfunction

    function automatic t_stim_row set_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CHAR_W-1:0] val);
        t_stim_row r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [LINES_W-1:0] pick_lines();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return LINES_W'($urandom_range(255));
        endcase
    endfunction

    // Drive one input transaction, wait for acceptance, record what it should produce
    task automatic send_item(input t_in it, input bit typed, input t_out want);
        t_out res;
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (parse_step(it, res)) out_due.push_back(typed ? want : res);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        send_item('{cmd: CMD_CHAR, char_in: c, affected_lines: pick_lines()}, 1'b0, '0);
    endtask

    task automatic send_end();
        send_item('{cmd: CMD_END, char_in: CHAR_W'($urandom_range(255)),
                    affected_lines: pick_lines()}, 1'b0, '0);
    endtask

    // Drop valid and hold until every result is out and the divider has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (out_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SPEED_CODE) speed_reg = val[SPEED_W-1:0];
        else if (idx == CFG_PAD_CHAR) pad_reg = val;
    endtask

    // Well-formed string: delay prefix, body characters, end
    task automatic send_string();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (n) send_char(CHAR_W'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(1)) begin
            send_char(CH_DOT);
            if ($urandom_range(9) < 7) begin
                send_char(CHAR_W'(CH_ZERO + $urandom_range(9)));
                repeat ($urandom_range(2)) send_char(CHAR_W'(CH_ZERO + $urandom_range(9)));
            end
        end
        if ($urandom_range(9) < 4) send_char(CH_STAR);
        repeat ($urandom_range(5)) send_char(CHAR_W'($urandom_range(255)));
        send_end();
    endtask

    // Single stray transaction, biased toward prefix characters
    task automatic send_noise();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(5))
            0:       c = CH_DOT;
            1:       c = CH_STAR;
            2:       c = CHAR_W'(CH_ZERO + $urandom_range(9));
            default: c = CHAR_W'($urandom_range(255));
        endcase
        send_item('{cmd: ($urandom_range(7) == 0) ? CMD_END : CMD_CHAR, char_in: c,
                    affected_lines: pick_lines()}, 1'b0, '0);
    endtask

    // Receiver stall pattern
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each result transaction with the oldest one due
    always @(posedge clk) begin : check_out
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (out_due.size() == 0) begin
                miss_count++;
                if (miss_count <= MAX_REPORTS)
                    $display("unexpected result: kind %0d char %02h count %0d",
                             out_data.kind, out_data.out_char, out_data.pad_count);
            end else begin
                want = out_due.pop_front();
                if (out_data !== want) begin
                    miss_count++;
                    if (miss_count <= MAX_REPORTS)
                        $display("mismatch: kind %0d/%0d char %02h/%02h count %0d/%0d",
                                 want.kind, out_data.kind, want.out_char, out_data.out_char,
                                 want.pad_count, out_data.pad_count);
                end
            end
        end
    end

    // End the run if no transaction moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("[terminal_padding_parser] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int start;
        logic [SPEED_W-1:0] spd;
        logic [CHAR_W-1:0]  pad;

        // Directed table: reset registers first (padding off), then extremes
        rows.push_back(feed(CMD_CHAR, "5", 8'h00));
        rows.push_back(feed(CMD_CHAR, "0", 8'h00));
        rows.push_back(feed_want(CMD_END, 8'h00, 8'hFF, KIND_END, 8'h00, '0));
        rows.push_back(feed_want(CMD_CHAR, "/", 8'h00, KIND_CHAR, "/", '0));
        rows.push_back(feed_want(CMD_CHAR, 8'h00, 8'h00, KIND_CHAR, 8'h00, '0));
        rows.push_back(feed_want(CMD_END, 8'hFF, 8'h00, KIND_END, 8'h00, '0));
        rows.push_back(set_reg(CFG_SPEED_CODE, 8'd14));
        rows.push_back(set_reg(CFG_PAD_CHAR, 8'hFF));
        repeat (5) rows.push_back(feed(CMD_CHAR, "9", 8'h00));
        rows.push_back(feed(CMD_CHAR, CH_DOT, 8'h00));
        rows.push_back(feed(CMD_CHAR, "9", 8'h00));
        rows.push_back(feed(CMD_CHAR, "9", 8'h00));
        rows.push_back(feed(CMD_CHAR, CH_STAR, 8'h00));
        rows.push_back(feed(CMD_END, 8'h00, 8'hFF));
        rows.push_back(feed_want(CMD_CHAR, 8'h00, 8'hFF, KIND_CHAR, 8'h00, '0));
        rows.push_back(feed_want(CMD_CHAR, 8'hFF, 8'hFF, KIND_CHAR, 8'hFF, '0));
        rows.push_back(feed_want(CMD_END, 8'h00, 8'h00, KIND_END, 8'hFF, '0));
        rows.push_back(feed(CMD_CHAR, CH_STAR, 8'h00));
        rows.push_back(feed_want(CMD_END, 8'h00, 8'h00, KIND_END, 8'hFF, '0));
        rows.push_back(set_reg(CFG_SPEED_CODE, {4'h0, SPEED_OVER}));
        rows.push_back(feed(CMD_CHAR, "1", 8'h00));
        rows.push_back(feed_want(CMD_END, 8'h00, 8'h01, KIND_END, 8'hFF, '0));
        rows.push_back(set_reg(CFG_SPEED_CODE, 8'd1));
        rows.push_back(set_reg(CFG_PAD_CHAR, 8'h00));
        rows.push_back(feed(CMD_CHAR, "3", 8'h00));
        rows.push_back(feed(CMD_CHAR, CH_DOT, 8'h00));
        rows.push_back(feed_want(CMD_CHAR, ":", 8'h00, KIND_CHAR, ":", '0));
        rows.push_back(feed(CMD_END, 8'h00, 8'h00));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table without gaps between items, settling before each register write
        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                settle();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_item(rows[i].item, rows[i].typed, rows[i].want);
            end
        end

        // Random phases: new register settings and idling pattern for each
        for (p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0:       begin spd = 4'd1;       pad = 8'h00; end
                1:       begin spd = 4'd14;      pad = 8'hFF; end
                2:       begin spd = SPEED_OFF;  pad = CHAR_W'($urandom_range(255)); end
                3:       begin spd = SPEED_OVER; pad = CHAR_W'($urandom_range(255)); end
                default: begin
                    spd = SPEED_W'($urandom_range(1, 14));
                    pad = CHAR_W'($urandom_range(255));
                end
            endcase
            if (p[0]) write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(1)),
                                CHAR_W'($urandom_range(255)));
            write_reg(CFG_SPEED_CODE, {4'h0, spd});
            write_reg(CFG_PAD_CHAR, pad);
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 76; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 76; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                if ($urandom_range(9) < 8) send_string();
                else send_noise();
            end
        end

        // Drain and report
        settle();
        if (miss_count == 0 && out_due.size() == 0)
            $display("[terminal_padding_parser] OK");
        else
            $display("[terminal_padding_parser] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/tpp_pkg.sv
src/tpp_ctrl.sv
src/tpp_dp.sv
src/terminal_padding_parser.sv
src/tpp_checker.sv
sim/terminal_padding_parser_tb.sv
